/* rtl/cdq_pkg.sv */
// Package with operation and status codes and the item types of the circular deque.
package cdq_pkg;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		op_t                operation;
		logic signed [31:0] push_value;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] popped_value;
		logic [3:0]         entry_count;
		logic               is_full;
		logic               is_empty;
	} out_item_t;

endpackage

/* rtl/cdq_mem.sv */
// Entry store of the deque: one write port, one read port with registered read data.
module cdq_mem import cdq_pkg::*; #(
	parameter int DEPTH      = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  logic [DATA_WIDTH-1:0]         wr_data,
	input  logic                          rd_en,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr,
	output logic [DATA_WIDTH-1:0]         rd_data
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	// Write the pushed entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read the popped entry into the registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/cdq_ctrl.sv */
// Pointer and count control of the deque: decodes each item and drives the store.
module cdq_ctrl import cdq_pkg::*; #(
	parameter int DEPTH      = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  in_item_t                      request,
	output logic                          done,
	output out_item_t                     result,
	output logic                          wr_en,
	output logic [$clog2(DEPTH)-1:0]      wr_addr,
	output logic [DATA_WIDTH-1:0]         wr_data,
	output logic                          rd_en,
	output logic [$clog2(DEPTH)-1:0]      rd_addr,
	input  logic [DATA_WIDTH-1:0]         rd_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;

	logic [AW-1:0] head_d, tail_d;
	logic [CW-1:0] count_d;
	status_t       status_d;
	logic          pop_ok;
	logic          is_push;
	logic          full_now, empty_now;
	logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
	logic [DATA_WIDTH+31:0] push_ext;
	logic [DATA_WIDTH+31:0] pop_ext;
	logic [CW+3:0]          count_ext;

	// Result stage registers
	logic          done_q;
	logic          pop_s1;
	status_t       status_s1;
	logic [CW-1:0] count_s1;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
		wrap_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
	endfunction

	assign head_inc  = wrap_inc(head_q);
	assign head_dec  = wrap_dec(head_q);
	assign tail_inc  = wrap_inc(tail_q);
	assign tail_dec  = wrap_dec(tail_q);
	assign full_now  = (count_q == CW'(DEPTH));
	assign empty_now = (count_q == '0);
	assign is_push   = (request.operation == OP_PUSH_FRONT) ||
	                   (request.operation == OP_PUSH_REAR);
	assign push_ext  = {{DATA_WIDTH{1'b0}}, request.push_value};
	assign wr_data   = push_ext[DATA_WIDTH-1:0];

	// Decode the operation: next pointers, count, status and store access
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		status_d = ST_DONE;
		pop_ok   = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		if (is_push) begin
			if (full_now) begin
				status_d = ST_FULL;
			end else begin
				wr_en   = start;
				count_d = count_q + CW'(1);
				if (empty_now) begin
					head_d  = '0;
					tail_d  = '0;
					wr_addr = '0;
				end else if (request.operation == OP_PUSH_FRONT) begin
					head_d  = head_dec;
					wr_addr = head_dec;
				end else begin
					tail_d  = tail_inc;
					wr_addr = tail_inc;
				end
			end
		end else begin
			if (empty_now) begin
				status_d = ST_EMPTY;
			end else begin
				pop_ok  = 1'b1;
				rd_en   = start;
				count_d = count_q - CW'(1);
				if (request.operation == OP_POP_FRONT) begin
					rd_addr = head_q;
					head_d  = head_inc;
				end else begin
					rd_addr = tail_q;
					tail_d  = tail_dec;
				end
				if (count_q == CW'(1)) begin
					head_d = '0;
					tail_d = '0;
				end
			end
		end
	end

	// Advance pointers and count on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= start;
			if (start) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				count_q <= count_d;
			end
		end
	end

	// Hold the result fields for the strobe cycle
	always_ff @(posedge clk) begin
		if (start) begin
			pop_s1    <= pop_ok;
			status_s1 <= status_d;
			count_s1  <= count_d;
		end
	end

	// Drive the result; popped data comes straight from the store read port
	assign pop_ext   = {32'b0, rd_data};
	assign count_ext = {4'b0, count_s1};

	always_comb begin
		result.status       = status_s1;
		result.popped_value = pop_s1 ? pop_ext[31:0] : 32'sd0;
		result.entry_count  = count_ext[3:0];
		result.is_full      = (count_s1 == CW'(DEPTH));
		result.is_empty     = (count_s1 == '0);
	end

	assign done = done_q;

endmodule

/* rtl/circular_double_ended_queue.sv */
// Circular double-ended queue: one item per cycle, result strobed in the next cycle.
// Each item's result appears on result with done high in the cycle after start.
// Throughput: one item every cycle; busy stays low, since a pop reads the store
// through its registered read port while the pointers update in the same edge.
// Reset clears pointers and count (queue empty); store entries stay undefined until pushed.
// The receiver cannot stall: every result is valid for exactly one cycle.
module circular_double_ended_queue import cdq_pkg::*; #(
	parameter int DEPTH      = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  request,
	output logic      done,
	output out_item_t result
);

	localparam int AW = $clog2(DEPTH);

	logic                  wr_en, rd_en;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic [DATA_WIDTH-1:0] wr_data, rd_data;

	// Accept an item in every cycle
	assign busy = 1'b0;

	cdq_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.done    (done),
		.result  (result),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cdq_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

/* verif/tb_circular_double_ended_queue.sv */
// Self-checking testbench for the circular double-ended queue with its own predictor.
`timescale 1ns / 1ps

module tb_circular_double_ended_queue;
	import cdq_pkg::*;

	localparam int DEPTH       = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_OPS  = 2000;

	typedef struct {
		in_item_t req;
		int       gap;
	} queued_op_t;

	logic      clk     = 1'b0;
	logic      arst_n  = 1'b0;
	logic      start   = 1'b0;
	in_item_t  request = '0;
	logic      busy;
	logic      done;
	out_item_t result;

	// Predictor state: shadow store, end pointers and fill level
	logic signed [31:0] slots [DEPTH];
	logic [2:0]         front_ptr = '0;
	logic [2:0]         back_ptr  = '0;
	logic [3:0]         fill      = '0;

	queued_op_t queued_ops [$];
	out_item_t  expected_results [$];
	queued_op_t next_op;
	out_item_t  want;
	logic       loaded        = 1'b0;
	logic       took_item     = 1'b0;
	logic       no_idle       = 1'b0;
	int         item_total    = -1;
	int         accepted_count = 0;
	int         error_count   = 0;
	int         cycle_count   = 0;

	circular_double_ended_queue u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one operation to the shadow deque and return the result it should give
	function automatic out_item_t apply_deque_op(in_item_t req);
		out_item_t r;
		r = '0;
		r.status = ST_DONE;
		case (req.operation)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (fill == DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// first entry of an empty queue always lands in slot 0
					if (fill == 0) begin
						front_ptr = '0;
						back_ptr  = '0;
						slots[0]  = req.push_value;
					end else if (req.operation == OP_PUSH_FRONT) begin
						front_ptr = front_ptr - 3'd1;
						slots[front_ptr] = req.push_value;
					end else begin
						back_ptr = back_ptr + 3'd1;
						slots[back_ptr] = req.push_value;
					end
					fill = fill + 4'd1;
				end
			end
			default: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (req.operation == OP_POP_FRONT) begin
						r.popped_value = slots[front_ptr];
						front_ptr = front_ptr + 3'd1;
					end else begin
						r.popped_value = slots[back_ptr];
						back_ptr = back_ptr - 3'd1;
					end
					fill = fill - 4'd1;
					// draining the queue resets both pointers
					if (fill == 0) begin
						front_ptr = '0;
						back_ptr  = '0;
					end
				end
			end
		endcase
		r.entry_count = fill;
		r.is_full     = (fill == DEPTH);
		r.is_empty    = (fill == 0);
		return r;
	endfunction

	task automatic add_item(op_t op, logic [31:0] value);
		queued_op_t q;
		q.req.operation  = op;
		q.req.push_value = value;
		q.gap = no_idle ? 0 : $urandom_range(0, 12);
		queued_ops.push_back(q);
	endtask

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_val, got_val);
			error_count++;
		end
	endtask

	// Drive the next item at the falling edge, after its idle gap
	always @(negedge clk) begin
		if (arst_n && (!start || took_item)) begin
			if (!loaded && queued_ops.size() != 0) begin
				next_op = queued_ops.pop_front();
				loaded  = 1'b1;
			end
			if (loaded && next_op.gap == 0) begin
				request <= next_op.req;
				start   <= 1'b1;
				loaded  = 1'b0;
			end else begin
				start <= 1'b0;
				if (loaded)
					next_op.gap--;
			end
		end
	end

	// Record accepted items and check each strobed result at the rising edge
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("circular_double_ended_queue test failed");
			$finish;
		end else begin
			took_item = arst_n && start && !busy;
			if (took_item) begin
				expected_results.push_back(apply_deque_op(request));
				accepted_count++;
			end
			if (arst_n && done === 1'b1) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, got %0h", $time, result);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(want.status), 32'(result.status));
					check_field("popped_value", want.popped_value, result.popped_value);
					check_field("entry_count", 32'(want.entry_count),
					            32'(result.entry_count));
					check_field("is_full", 32'(want.is_full), 32'(result.is_full));
					check_field("is_empty", 32'(want.is_empty), 32'(result.is_empty));
				end
			end
		end
	end

	initial begin
		logic push_bias;
		logic [31:0] value;
		op_t op;

		// directed: empty pops, extremes, empty-queue pushes, fill to full, wrap
		add_item(OP_POP_FRONT, $urandom);
		add_item(OP_POP_REAR, $urandom);
		add_item(OP_PUSH_FRONT, 32'h7fff_ffff);
		add_item(OP_PUSH_REAR, 32'h8000_0000);
		add_item(OP_POP_FRONT, $urandom);
		add_item(OP_POP_REAR, $urandom);
		add_item(OP_PUSH_FRONT, 32'hffff_ffff);
		add_item(OP_POP_REAR, $urandom);
		add_item(OP_PUSH_REAR, 32'h0000_0000);
		add_item(OP_PUSH_FRONT, 32'h5555_5555);
		add_item(OP_PUSH_FRONT, 32'haaaa_aaaa);
		add_item(OP_PUSH_REAR, 32'hffff_ffff);
		add_item(OP_PUSH_FRONT, 32'h8000_0000);
		add_item(OP_PUSH_REAR, 32'h7fff_ffff);
		add_item(OP_PUSH_FRONT, 32'h0000_0001);
		add_item(OP_PUSH_REAR, 32'hfffffffe);
		add_item(OP_PUSH_FRONT, 32'h1234_5678);
		add_item(OP_PUSH_REAR, 32'h8765_4321);
		add_item(OP_POP_FRONT, $urandom);
		add_item(OP_PUSH_REAR, 32'hdead_beef);
		add_item(OP_POP_REAR, $urandom);
		add_item(OP_POP_REAR, $urandom);
		add_item(OP_PUSH_FRONT, 32'hcafe_f00d);

		// random: stretches that are fill-biased or drain-biased at random, so the queue
		// swings between full and empty; some stretches run with no idle gaps
		push_bias = 1'b1;
		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (i % 40 == 0) begin
				push_bias = 1'($urandom_range(0, 1));
				no_idle   = ($urandom_range(0, 3) == 0);
			end
			if (($urandom_range(0, 99) < 75) == push_bias)
				op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
			else
				op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
			case ($urandom_range(0, 7))
				0:       value = 32'h8000_0000;
				1:       value = 32'h7fff_ffff;
				2:       value = 32'h0000_0000;
				3:       value = 32'hffff_ffff;
				default: value = $urandom;
			endcase
			add_item(op, value);
		end
		item_total = queued_ops.size();

		// hold reset, then release it at a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_count != item_total)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (error_count == 0)
			$display("circular_double_ended_queue test passed");
		else
			$display("circular_double_ended_queue test failed");
		$finish;
	end

endmodule

/* circular_double_ended_queue.f */
rtl/cdq_pkg.sv
rtl/cdq_mem.sv
rtl/cdq_ctrl.sv
rtl/circular_double_ended_queue.sv
verif/tb_circular_double_ended_queue.sv
